FILE: sv/epc_pkg.sv
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types and constants for the eBPF program preflight check.
// ----------------------------------------------------------------------------
package epc_pkg;

  localparam int MAX_SLOTS_DEF  = 4096;
  localparam int CALL_COUNT_DEF = 64;

  localparam int OPC_W      = 8;
  localparam int REGNUM_W   = 4;
  localparam int OFFSET_W   = 16;
  localparam int IMM_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int BYTES_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_NO_RETURN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_CALLS   = 2'd2;

  localparam logic [BYTES_W-1:0] PROGRAM_BYTES_RST = 16'd8;

  // opcodes and fields of interest
  localparam logic [OPC_W-1:0]    OPC_LDDW      = 8'h18;
  localparam logic [OPC_W-1:0]    OPC_CALL      = 8'h85;
  localparam logic [OPC_W-1:0]    OPC_EXIT      = 8'h95;
  localparam logic [2:0]          CLASS_JMP     = 3'h5;
  localparam logic [REGNUM_W-1:0] REG_NUM_LIMIT = 4'd11;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_LEN   = 3'd1,
    ST_REG   = 3'd2,
    ST_JUMP  = 3'd3,
    ST_CALL  = 3'd4,
    ST_NORET = 3'd5
  } status_t;

endpackage

FILE: sv/ebpf_program_preflight_check.sv
// A last slot is held in the input stage register; its status then moves to the output register, shown on out_valid.
// Throughput: one instruction slot per cycle, sustained, when out_stall is low.
// A waiting status holds in the output register while the input stage still takes a slot.
// Reset (synchronous, rst_n low) clears slot index, skip flag, first error and
// all valid flags; program_bytes returns to 8, allow_no_return and allowed_calls to 0.
// ----------------------------------------------------------------------------
// ebpf_program_preflight_check
// Streams eBPF instruction slots, checks program length, registers, jump bounds, calls and
// the final exit, and reports one status per program at the last slot.
// ----------------------------------------------------------------------------
module ebpf_program_preflight_check #(
  parameter int MAX_SLOTS  = epc_pkg::MAX_SLOTS_DEF,
  parameter int CALL_COUNT = epc_pkg::CALL_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [epc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [epc_pkg::CFG_DATA_W-1:0]       cfg_data,
  // slot input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [epc_pkg::OPC_W-1:0]            in_opcode,
  input  logic [epc_pkg::REGNUM_W-1:0]         in_dest_reg,
  input  logic [epc_pkg::REGNUM_W-1:0]         in_source_reg,
  input  logic signed [epc_pkg::OFFSET_W-1:0]  in_jump_offset,
  input  logic [epc_pkg::IMM_W-1:0]            in_imm_value,
  input  logic                                 in_last_slot,
  // status output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [epc_pkg::STATUS_W-1:0]         out_status
);
  import epc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SLOTS + 1);
  localparam int CALL_W = (CALL_COUNT > 1) ? $clog2(CALL_COUNT) : 1;
  localparam int TGT_W  = ((IDX_W > OFFSET_W) ? IDX_W : OFFSET_W) + 2;
  localparam int CNT_W  = BYTES_W - 3;

  // configuration registers
  logic [BYTES_W-1:0]    program_bytes_r;
  logic                  allow_no_return_r;
  logic [CALL_COUNT-1:0] allowed_calls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      program_bytes_r   <= PROGRAM_BYTES_RST;
      allow_no_return_r <= 1'b0;
      allowed_calls_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROGRAM_BYTES:   program_bytes_r   <= cfg_data[BYTES_W-1:0];
        CFG_ALLOW_NO_RETURN: allow_no_return_r <= cfg_data[0];
        CFG_ALLOWED_CALLS:   allowed_calls_r   <= cfg_data[CALL_COUNT-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                       s1_valid_r;
  logic [OPC_W-1:0]           s1_opcode_r;
  logic [REGNUM_W-1:0]        s1_dest_r;
  logic [REGNUM_W-1:0]        s1_src_r;
  logic [OFFSET_W-1:0]        s1_offset_r;
  logic [IMM_W-1:0]           s1_imm_r;
  logic                       s1_last_r;

  // program state
  logic [IDX_W-1:0]           slot_index_r, slot_index_nxt;
  logic                       skip_next_r, skip_next_nxt;
  status_t                    first_error_r, first_error_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]        out_status_r, out_status_nxt;

  logic                       advance;
  logic                       in_xfer;
  logic                       s1_fire;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_opcode_r <= in_opcode;
      s1_dest_r   <= in_dest_reg;
      s1_src_r    <= in_source_reg;
      s1_offset_r <= in_jump_offset;
      s1_imm_r    <= in_imm_value;
      s1_last_r   <= in_last_slot;
    end
  end

  // slot checks
  logic [TGT_W-1:0]  jump_target;
  logic [TGT_W-1:0]  slot_count;
  logic              bad_reg;
  logic              bad_jump;
  logic              bad_call;
  logic [CALL_W-1:0] call_idx;
  status_t           slot_err;

  assign jump_target = {{(TGT_W-IDX_W){1'b0}}, slot_index_r}
                     + {{(TGT_W-OFFSET_W){s1_offset_r[OFFSET_W-1]}}, s1_offset_r};
  assign slot_count  = {{(TGT_W-CNT_W){1'b0}}, program_bytes_r[BYTES_W-1:3]};
  assign call_idx    = s1_imm_r[CALL_W-1:0];

  assign bad_reg  = (s1_dest_r >= REG_NUM_LIMIT) || (s1_src_r >= REG_NUM_LIMIT);
  assign bad_jump = (s1_opcode_r[2:0] == CLASS_JMP)
                 && (jump_target[TGT_W-1] || (jump_target >= slot_count));
  // out-of-range call numbers are caught by the compare before the bitmap lookup
  assign bad_call = (s1_opcode_r == OPC_CALL)
                 && ((s1_imm_r >= IMM_W'(CALL_COUNT)) || !allowed_calls_r[call_idx]);

  always_comb begin
    if (bad_reg) begin
      slot_err = ST_REG;
    end else if (s1_opcode_r == OPC_LDDW) begin
      slot_err = ST_OK;
    end else if (bad_jump) begin
      slot_err = ST_JUMP;
    end else if (bad_call) begin
      slot_err = ST_CALL;
    end else begin
      slot_err = ST_OK;
    end
  end

  always_comb begin
    slot_index_nxt  = slot_index_r;
    skip_next_nxt   = skip_next_r;
    first_error_nxt = first_error_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;

    if (s1_fire) begin
      if (skip_next_r) begin
        // second half of a double-length load is not checked
        skip_next_nxt = 1'b0;
      end else begin
        if (first_error_r == ST_OK) begin
          first_error_nxt = slot_err;
        end
        skip_next_nxt = (slot_err == ST_OK) && (s1_opcode_r == OPC_LDDW);
      end

      if (!s1_last_r) begin
        if (slot_index_r < IDX_W'(MAX_SLOTS)) begin
          slot_index_nxt = slot_index_r + 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b1;
        if (program_bytes_r[2:0] != 3'd0) begin
          out_status_nxt = ST_LEN;
        end else if (first_error_nxt != ST_OK) begin
          out_status_nxt = first_error_nxt;
        end else if ((s1_opcode_r != OPC_EXIT) && !allow_no_return_r) begin
          out_status_nxt = ST_NORET;
        end else begin
          out_status_nxt = ST_OK;
        end
        slot_index_nxt  = '0;
        skip_next_nxt   = 1'b0;
        first_error_nxt = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_index_r  <= '0;
      skip_next_r   <= 1'b0;
      first_error_r <= ST_OK;
      out_valid_r   <= 1'b0;
    end else begin
      slot_index_r  <= slot_index_nxt;
      skip_next_r   <= skip_next_nxt;
      first_error_r <= first_error_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

FILE: verif/ebpf_program_preflight_check_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebpf_program_preflight_check_test
// Streams eBPF instruction slots into the preflight checker and compares
// every status transfer against a cycle-free model of the checks kept in
// the bench. Covers directed corner programs, output backpressure and
// random programs under several idle and stall mixes.
// ----------------------------------------------------------------------------
module ebpf_program_preflight_check_test;
  import epc_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [OPC_W-1:0] OPC_ADD64_IMM = 8'h07;
  localparam logic [OPC_W-1:0] OPC_JA        = 8'h05;
  localparam logic [OPC_W-1:0] OPC_JEQ_IMM   = 8'h15;
  localparam logic [OPC_W-1:0] OPC_MOV64_IMM = 8'hb7;
  localparam logic [OPC_W-1:0] OPC_MOV64_REG = 8'hbf;

  typedef struct packed {
    logic [OPC_W-1:0]    opcode;
    logic [REGNUM_W-1:0] dest_reg;
    logic [REGNUM_W-1:0] source_reg;
    logic [OFFSET_W-1:0] jump_offset;
    logic [IMM_W-1:0]    imm_value;
    logic                last_slot;
  } slot_t;

  logic                   clk;
  logic                   rst_n          = 1'b0;
  logic                   cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index      = '0;
  logic [CFG_DATA_W-1:0]  cfg_data       = '0;
  logic                   in_valid       = 1'b0;
  logic                   in_stall;
  logic [OPC_W-1:0]       in_opcode      = '0;
  logic [REGNUM_W-1:0]    in_dest_reg    = '0;
  logic [REGNUM_W-1:0]    in_source_reg  = '0;
  logic [OFFSET_W-1:0]    in_jump_offset = '0;
  logic [IMM_W-1:0]       in_imm_value   = '0;
  logic                   in_last_slot   = 1'b0;
  logic                   out_valid;
  logic                   out_stall      = 1'b0;
  logic [STATUS_W-1:0]    out_status;

  // model of the checker
  logic [BYTES_W-1:0]     prog_bytes   = PROGRAM_BYTES_RST;
  bit                     no_return_ok = 1'b0;
  logic [CFG_DATA_W-1:0]  call_map     = '0;
  int                     slot_pos     = 0;
  bit                     skip_half    = 1'b0;
  status_t                first_fault  = ST_OK;

  status_t expected_status[$];
  int      status_tally[8];
  int      slots_sent     = 0;
  int      mismatch_count = 0;
  int      idle_pct       = 0;
  int      stall_pct      = 0;
  int      hold_left      = 0;

  ebpf_program_preflight_check dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_dest_reg    (in_dest_reg),
    .in_source_reg  (in_source_reg),
    .in_jump_offset (in_jump_offset),
    .in_imm_value   (in_imm_value),
    .in_last_slot   (in_last_slot),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic status_t slot_fault(slot_t s);
    int target;
    if (s.dest_reg >= REG_NUM_LIMIT || s.source_reg >= REG_NUM_LIMIT) return ST_REG;
    if (s.opcode == OPC_LDDW) return ST_OK;
    if (s.opcode[2:0] == CLASS_JMP) begin
      target = slot_pos + int'($signed(s.jump_offset));
      if (target < 0 || target >= int'(prog_bytes[15:3])) return ST_JUMP;
    end
    if (s.opcode == OPC_CALL) begin
      if (s.imm_value >= 32'(CALL_COUNT_DEF) || !call_map[s.imm_value[5:0]]) return ST_CALL;
    end
    return ST_OK;
  endfunction

  task automatic track_slot(slot_t s);
    status_t fault;
    status_t verdict;
    if (skip_half) begin
      skip_half = 1'b0;
    end else begin
      fault = slot_fault(s);
      if (first_fault == ST_OK) first_fault = fault;
      if (fault == ST_OK && s.opcode == OPC_LDDW) skip_half = 1'b1;
    end
    if (!s.last_slot) begin
      if (slot_pos < MAX_SLOTS_DEF) slot_pos++;
    end else begin
      if (prog_bytes[2:0] != 3'd0) verdict = ST_LEN;
      else if (first_fault != ST_OK) verdict = first_fault;
      else if (s.opcode != OPC_EXIT && !no_return_ok) verdict = ST_NORET;
      else verdict = ST_OK;
      expected_status.push_back(verdict);
      status_tally[verdict]++;
      slot_pos    = 0;
      skip_half   = 1'b0;
      first_fault = ST_OK;
    end
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 50) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // one slot transfer, with an optional idle gap in front
  task automatic send_slot(slot_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= s.opcode;
    in_dest_reg    <= s.dest_reg;
    in_source_reg  <= s.source_reg;
    in_jump_offset <= s.jump_offset;
    in_imm_value   <= s.imm_value;
    in_last_slot   <= s.last_slot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_slot(s);
    slots_sent++;
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // upper bits above each register's width carry junk on purpose
  task automatic write_config(logic [BYTES_W-1:0] bytes, bit noret, logic [CFG_DATA_W-1:0] calls);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PROGRAM_BYTES;
    cfg_data  <= {$urandom, 16'($urandom), bytes};
    @(posedge clk);
    cfg_index <= CFG_ALLOW_NO_RETURN;
    cfg_data  <= {$urandom, 31'($urandom), noret};
    @(posedge clk);
    cfg_index <= CFG_ALLOWED_CALLS;
    cfg_data  <= calls;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we       <= 1'b0;
    prog_bytes   = bytes;
    no_return_ok = noret;
    call_map     = calls;
  endtask

  function automatic slot_t make_slot(logic [OPC_W-1:0] op, logic [REGNUM_W-1:0] dst,
                                      logic [REGNUM_W-1:0] src, logic [OFFSET_W-1:0] off,
                                      logic [IMM_W-1:0] imm, logic last);
    slot_t s;
    s.opcode      = op;
    s.dest_reg    = dst;
    s.source_reg  = src;
    s.jump_offset = off;
    s.imm_value   = imm;
    s.last_slot   = last;
    return s;
  endfunction

  function automatic slot_t random_slot();
    slot_t s;
    s.opcode      = 8'($urandom);
    s.dest_reg    = 4'($urandom);
    s.source_reg  = 4'($urandom);
    s.jump_offset = 16'($urandom);
    s.imm_value   = $urandom;
    s.last_slot   = 1'b0;
    return s;
  endfunction

  // mostly legal registers, branch targets near the program bounds
  function automatic slot_t shaped_slot(int pos, int span);
    slot_t s;
    int pick;
    int target;
    s = random_slot();
    if ($urandom_range(99) < 98) s.dest_reg = 4'($urandom_range(10));
    if ($urandom_range(99) < 98) s.source_reg = 4'($urandom_range(10));
    pick   = $urandom_range(99);
    target = int'($urandom_range(span + 1)) - 1;
    if (pick < 25) begin
      s.opcode = {5'($urandom), CLASS_JMP};
      if ($urandom_range(9) != 0) s.jump_offset = 16'(target - pos);
    end else if (pick < 45) begin
      s.opcode = OPC_CALL;
      if ($urandom_range(99) < 85) s.imm_value = $urandom_range(CALL_COUNT_DEF - 1);
    end else if (pick < 58) begin
      s.opcode = OPC_LDDW;
    end else if (pick < 70) begin
      s.opcode      = OPC_EXIT;
      s.jump_offset = 16'(target - pos);
    end
    return s;
  endfunction

  task automatic send_program(int span);
    slot_t s;
    int len;
    int i;
    int target;
    bit noise;
    noise = ($urandom_range(99) < 10);
    len   = ($urandom_range(99) < 70) ? span : $urandom_range(span + 3, 1);
    i     = 0;
    while (i < len) begin
      s = noise ? random_slot() : shaped_slot(i, span);
      if (!noise && i == len - 1 && $urandom_range(99) < 80) begin
        target        = $urandom_range(span - 1);
        s.opcode      = OPC_EXIT;
        s.jump_offset = 16'(target - i);
      end
      s.last_slot = (i == len - 1);
      send_slot(s);
      i++;
      // second half of a double load carries raw immediate data
      if (!noise && s.opcode == OPC_LDDW && i < len) begin
        s           = random_slot();
        s.last_slot = (i == len - 1);
        send_slot(s);
        i++;
      end
    end
  endtask

  task automatic test_directed_programs();
    // reset settings: 8 bytes, exit required, no calls
    send_slot(make_slot(OPC_EXIT, 0, 0, 0, 0, 1'b1));
    send_slot(make_slot(OPC_ADD64_IMM, 0, 0, 0, 0, 1'b1));
    // ragged length outranks a bad register
    write_config(16'd12, 1'b0, '0);
    send_slot(make_slot(OPC_EXIT, 4'd15, 4'd15, 0, 0, 1'b1));
    // zero length: no length error, every branch target is out of range
    write_config(16'd0, 1'b1, '0);
    send_slot(make_slot(OPC_ADD64_IMM, 0, 0, 0, 0, 1'b1));
    send_slot(make_slot(OPC_EXIT, 0, 0, 0, 0, 1'b1));
    // calls 0, 5 and 63 exist
    write_config(16'h8000, 1'b0, 64'h8000_0000_0000_0021);
    send_slot(make_slot(OPC_CALL, 4'd10, 4'd10, 0, 32'd0, 1'b0));
    send_slot(make_slot(OPC_CALL, 0, 0, 0, 32'd63, 1'b0));
    send_slot(make_slot(OPC_JA, 0, 0, 16'hFFFE, 0, 1'b0));
    send_slot(make_slot(OPC_LDDW, 4'd10, 4'd10, 0, 32'hFFFF_FFFF, 1'b0));
    send_slot(make_slot(8'hFF, 4'd15, 4'd15, 16'h8000, 32'hFFFF_FFFF, 1'b0));
    send_slot(make_slot(OPC_EXIT, 0, 0, 0, 0, 1'b1));
    send_slot(make_slot(OPC_CALL, 0, 0, 0, 32'd64, 1'b1));
    send_slot(make_slot(OPC_CALL, 0, 0, 0, 32'hFFFF_FFFF, 1'b0));
    send_slot(make_slot(OPC_EXIT, 0, 0, 0, 0, 1'b1));
    send_slot(make_slot(OPC_CALL, 0, 0, 0, 32'd1, 1'b1));
    send_slot(make_slot(OPC_JA, 0, 0, 16'hFFFF, 0, 1'b1));
    send_slot(make_slot(OPC_JEQ_IMM, 0, 0, 16'h7FFF, 0, 1'b1));
    // first error in stream order wins
    send_slot(make_slot(OPC_MOV64_IMM, 4'd11, 0, 0, 0, 1'b0));
    send_slot(make_slot(OPC_JA, 0, 0, 16'h8000, 0, 1'b1));
    send_slot(make_slot(OPC_LDDW, 0, 4'd11, 0, 0, 1'b1));
    // double load as last slot must not leak its skip into the next program
    send_slot(make_slot(OPC_LDDW, 0, 0, 0, 0, 1'b1));
    send_slot(make_slot(OPC_MOV64_IMM, 4'd12, 0, 0, 0, 1'b1));
    // the exit check looks at the second half of a double load
    send_slot(make_slot(OPC_LDDW, 0, 0, 0, 0, 1'b0));
    send_slot(make_slot(OPC_EXIT, 4'd15, 4'd15, 16'h8000, 0, 1'b1));
    send_slot(make_slot(OPC_LDDW, 0, 0, 0, 0, 1'b0));
    send_slot(make_slot(8'h00, 0, 0, 0, 0, 1'b1));
    write_config(16'd32, 1'b1, '1);
    send_slot(make_slot(OPC_MOV64_REG, 0, 0, 0, 0, 1'b1));
    send_slot(make_slot(OPC_JA, 0, 0, 16'd3, 0, 1'b0));
    send_slot(make_slot(OPC_JA, 0, 0, 16'd3, 0, 1'b1));
    send_slot(make_slot(OPC_CALL, 0, 0, 0, 32'd40, 1'b1));
  endtask

  // receiver holds off while one-slot programs keep coming
  task automatic test_output_backpressure();
    int n;
    write_config(PROGRAM_BYTES_RST, 1'b0, '0);
    hold_left <= HOLD_CYCLES;
    for (n = 0; n < 40; n++) begin
      send_slot(make_slot((n % 3 == 0) ? OPC_ADD64_IMM : OPC_EXIT, 0, 0, 0, 0, 1'b1));
    end
  endtask

  task automatic test_random_programs(int idle, int stall, int budget);
    logic [BYTES_W-1:0]    bytes;
    logic [CFG_DATA_W-1:0] calls;
    int lb;
    int span;
    int start;
    idle_pct  = idle;
    stall_pct <= stall;
    start     = slots_sent;
    while (slots_sent - start < budget) begin
      lb = $urandom_range(10, 1);
      case ($urandom_range(9))
        0:       bytes = '0;
        1:       bytes = 16'hFFF8;
        2:       bytes = 16'hFFFF;
        3:       bytes = 16'($urandom);
        4:       bytes = 16'h8000;
        default: bytes = 16'(lb * 8);
      endcase
      case ($urandom_range(3))
        0:       calls = '0;
        1:       calls = '1;
        default: calls = {$urandom, $urandom};
      endcase
      write_config(bytes, 1'($urandom), calls);
      span = (bytes[15:3] == 0 || int'(bytes[15:3]) >= lb) ? lb : int'(bytes[15:3]);
      repeat ($urandom_range(8, 3)) send_program(span);
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_status
    status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        report_mismatch($sformatf("status %0d with no program pending", out_status));
      end else begin
        want = expected_status.pop_front();
        if (out_status !== want)
          report_mismatch($sformatf("status got %0d expected %0d", out_status, want));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_programs();
    test_output_backpressure();
    test_random_programs(0, 0, 310);
    test_random_programs(75, 0, 310);
    test_random_programs(0, 75, 310);
    test_random_programs(23, 23, 310);
    settle_block();
    repeat (8) @(posedge clk);
    $display("%0d slot transfers, %0d mismatches; statuses ok %0d, length %0d, register %0d,",
             slots_sent, mismatch_count, status_tally[ST_OK], status_tally[ST_LEN],
             status_tally[ST_REG]);
    $display("jump %0d, call %0d, missing exit %0d", status_tally[ST_JUMP],
             status_tally[ST_CALL], status_tally[ST_NORET]);
    if (mismatch_count == 0 && expected_status.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
